// ===== hdl/bltd_pkg.sv =====
// Shared types and constants for the backlight level-to-duty mapper.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps

package bltd_pkg;

    // Drive modes; the unused code behaves as the PWM counter mode.
    localparam logic [1:0] MODE_PWM  = 2'd0;
    localparam logic [1:0] MODE_VESA = 2'd1;
    localparam logic [1:0] MODE_HDR  = 2'd2;

    // Result commands.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_DRIVE = 2'd1;
    localparam logic [1:0] CMD_OFF   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_DRIVE_MODE   = 3'd0;
    localparam logic [2:0] REG_MIN_DUTY_PCT = 3'd1;
    localparam logic [2:0] REG_MAX_DUTY_PCT = 3'd2;
    localparam logic [2:0] REG_MAX_LEVEL    = 3'd3;
    localparam logic [2:0] REG_PWM_FREQ_HZ  = 3'd4;
    localparam logic [2:0] REG_SRC_CLOCK_HZ = 3'd5;
    localparam logic [2:0] REG_VESA_BITS    = 3'd6;

    // Arithmetic constants.
    localparam logic [6:0]  PCT_FULL   = 7'd100;
    localparam logic [31:0] HDR_PERIOD = 32'd512;
    localparam logic [31:0] HDR_FLOOR  = 32'd3;

    // Shared divider geometry: two quotient bits per cycle.
    localparam int DIV_W       = 40;
    localparam int DVS_W       = 16;
    localparam int DIV_STEPS   = DIV_W / 2;
    localparam int DIV_STEP_W  = $clog2(DIV_STEPS);
    localparam logic [DVS_W-1:0] PCT_DIVISOR = 16'd100;

    // Multiplier operand selects.
    localparam logic [1:0] MS_LO  = 2'd0;
    localparam logic [1:0] MS_GAP = 2'd1;
    localparam logic [1:0] MS_HI  = 2'd2;
    localparam logic [1:0] MS_LVL = 2'd3;

    // Divider operand selects.
    localparam logic [1:0] DSEL_CLK  = 2'd0;
    localparam logic [1:0] DSEL_PROD = 2'd1;
    localparam logic [1:0] DSEL_SPAN = 2'd2;

    // Datapath register store codes.
    localparam logic [2:0] ST_NONE = 3'd0;
    localparam logic [2:0] ST_PER  = 3'd1;
    localparam logic [2:0] ST_LO   = 3'd2;
    localparam logic [2:0] ST_GAP  = 3'd3;
    localparam logic [2:0] ST_CNT  = 3'd4;
    localparam logic [2:0] ST_SUM  = 3'd5;

    typedef struct packed {
        logic [1:0]  drive_mode;
        logic [6:0]  min_duty_pct;
        logic [6:0]  max_duty_pct;
        logic [7:0]  max_level;
        logic [15:0] pwm_freq_hz;
        logic [31:0] source_clock_hz;
        logic [4:0]  vesa_bits;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        drive_mode:      MODE_PWM,
        min_duty_pct:    7'd10,
        max_duty_pct:    7'd90,
        max_level:       8'd100,
        pwm_freq_hz:     16'd1000,
        source_clock_hz: 32'd128000000,
        vesa_bits:       5'd16
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       per_aux;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       div_start;
        logic [1:0] div_sel;
        logic [2:0] store;
        logic       finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic blank;
        logic mode_pwm;
        logic lvl_ge_max;
        logic lvl_zero;
        logic div_busy;
        logic div_done;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== hdl/bltd_div.sv =====
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on bltd_pkg for its widths.
`timescale 1ns / 1ps

module bltd_div
    import bltd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]      rem_reg;
    logic [DVS_W-1:0]      rem_next;
    logic [DIV_W-1:0]      quo_reg;
    logic [DIV_W-1:0]      quo_next;
    logic [DVS_W-1:0]      dvs_reg;

    // Two shift-and-subtract steps of the restoring division.
    always_comb
    begin
        logic [DVS_W:0] trial;
        logic [DVS_W:0] diff;
        logic           ge;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial    = {rem_next, quo_next[DIV_W-1]};
            diff     = trial - {1'b0, dvs_reg};
            ge       = (trial >= {1'b0, dvs_reg});
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_next[DIV_W-2:0], ge};
        end
    end

    // Step counter and handshake flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/bltd_dp.sv =====
// Datapath of the level-to-duty mapper: operand registers, shared multiplier,
// shared divider, result formatting and the output register.
// Depends on bltd_pkg and bltd_div.
`timescale 1ns / 1ps

module bltd_dp
    import bltd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    input  logic [7:0]  in_level,
    input  logic        in_blank,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [1:0]  out_command,
    output logic [31:0] out_period,
    output logic [31:0] out_duty,
    output logic        out_run,
    output logic [7:0]  out_level
);

    logic [7:0]       lvl_reg;
    logic             blank_reg;
    logic [31:0]      per_reg;
    logic [31:0]      lo_reg;
    logic [31:0]      gap_reg;
    logic [31:0]      cnt_reg;
    logic [39:0]      prod_reg;
    logic             bl_on_reg;
    logic             bl_on_next;
    logic             out_valid_reg;
    logic [1:0]       out_cmd_reg;
    logic [31:0]      out_per_reg;
    logic [31:0]      out_duty_reg;
    logic             out_run_reg;
    logic [7:0]       out_lvl_reg;

    logic [6:0]       lo_pct;
    logic [6:0]       hi_pct;
    logic [6:0]       gap_pct;
    logic [32:0]      vesa_full;
    logic [31:0]      per_aux;
    logic [7:0]       mul_a;
    logic [31:0]      mul_b;
    logic [39:0]      mul_full;
    logic [32:0]      lo_gap;
    logic [31:0]      span;
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_busy;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic             mode_pwm;
    logic [1:0]       fin_cmd;
    logic [31:0]      fin_per;
    logic [31:0]      fin_duty;
    logic             fin_run;
    logic [7:0]       fin_lvl;

    // Percentages above 100 count as 100.
    assign lo_pct  = (cfg.min_duty_pct > PCT_FULL) ? PCT_FULL : cfg.min_duty_pct;
    assign hi_pct  = (cfg.max_duty_pct > PCT_FULL) ? PCT_FULL : cfg.max_duty_pct;
    assign gap_pct = PCT_FULL - hi_pct;

    assign mode_pwm = (cfg.drive_mode != MODE_VESA) && (cfg.drive_mode != MODE_HDR);

    // Period for the two AUX modes.
    assign vesa_full = (33'd1 << cfg.vesa_bits) - 33'd1;
    assign per_aux   = (cfg.drive_mode == MODE_HDR) ? HDR_PERIOD : vesa_full[31:0];

    // Shared multiplier: a percentage times the period, or the level times
    // the per-level step.
    always_comb
    begin
        case (cmd.mul_sel)
            MS_LO:   mul_a = {1'b0, lo_pct};
            MS_GAP:  mul_a = {1'b0, gap_pct};
            MS_HI:   mul_a = {1'b0, hi_pct};
            MS_LVL:  mul_a = lvl_reg;
            default: mul_a = '0;
        endcase
    end
    assign mul_b    = (cmd.mul_sel == MS_LVL) ? div_quo[31:0] : per_reg;
    assign mul_full = {32'd0, mul_a} * {8'd0, mul_b};

    // Duty span between the low and high bounds, saturating at zero.
    assign lo_gap = {1'b0, lo_reg} + {1'b0, gap_reg};
    assign span   = ({1'b0, per_reg} >= lo_gap) ? (per_reg - lo_reg - gap_reg) : 32'd0;

    // Divider operand selection.
    always_comb
    begin
        case (cmd.div_sel)
            DSEL_CLK:
            begin
                div_dividend = {8'd0, cfg.source_clock_hz};
                div_divisor  = (cfg.pwm_freq_hz == 16'd0) ? 16'd1 : cfg.pwm_freq_hz;
            end
            DSEL_PROD:
            begin
                div_dividend = prod_reg;
                div_divisor  = PCT_DIVISOR;
            end
            DSEL_SPAN:
            begin
                div_dividend = {8'd0, span};
                div_divisor  = {8'd0, cfg.max_level};
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = PCT_DIVISOR;
            end
        endcase
    end
    assign div_start = cmd.div_start;

    bltd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Item capture, with the level clamped to the configured maximum.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lvl_reg   <= (in_level > cfg.max_level) ? cfg.max_level : in_level;
            blank_reg <= in_blank;
        end
    end

    // Working registers loaded by the controller's per_aux, mul_en and store commands.
    always_ff @(posedge clk)
    begin
        if (cmd.per_aux)
        begin
            per_reg <= per_aux;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_full;
        end
        case (cmd.store)
            ST_PER:
            begin
                per_reg <= div_quo[31:0];
            end
            ST_LO:
            begin
                lo_reg  <= div_quo[31:0];
                cnt_reg <= div_quo[31:0];
            end
            ST_GAP:
            begin
                gap_reg <= div_quo[31:0];
            end
            ST_CNT:
            begin
                cnt_reg <= div_quo[31:0];
            end
            ST_SUM:
            begin
                cnt_reg <= prod_reg[31:0] + lo_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Final formatting of the result item per mode.
    always_comb
    begin
        fin_cmd    = CMD_DRIVE;
        fin_per    = per_reg;
        fin_duty   = cnt_reg;
        fin_run    = 1'b1;
        fin_lvl    = lvl_reg;
        bl_on_next = 1'b1;
        if (blank_reg)
        begin
            fin_cmd    = bl_on_reg ? CMD_OFF : CMD_NONE;
            fin_per    = '0;
            fin_duty   = '0;
            fin_run    = 1'b0;
            fin_lvl    = '0;
            bl_on_next = 1'b0;
        end
        else if (cfg.drive_mode == MODE_HDR)
        begin
            if (cnt_reg == 32'd0)
            begin
                fin_duty = HDR_FLOOR;
            end
        end
        else if (mode_pwm)
        begin
            if (cnt_reg == 32'd0)
            begin
                fin_run = 1'b0;
            end
            else if (cnt_reg >= per_reg)
            begin
                // Full on is signaled by an end value of zero.
                fin_duty = '0;
            end
        end
    end

    // Backlight state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bl_on_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            bl_on_reg     <= bl_on_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_cmd_reg  <= fin_cmd;
            out_per_reg  <= fin_per;
            out_duty_reg <= fin_duty;
            out_run_reg  <= fin_run;
            out_lvl_reg  <= fin_lvl;
        end
    end

    assign sts.blank      = blank_reg;
    assign sts.mode_pwm   = mode_pwm;
    assign sts.lvl_ge_max = (lvl_reg >= cfg.max_level);
    assign sts.lvl_zero   = (lvl_reg == 8'd0);
    assign sts.div_busy   = div_busy;
    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_command = out_cmd_reg;
    assign out_period  = out_per_reg;
    assign out_duty    = out_duty_reg;
    assign out_run     = out_run_reg;
    assign out_level   = out_lvl_reg;

    // A blanked item always yields an idle, zero result.
    a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && blank_reg) |=>
            (out_duty_reg == 32'd0 && !out_run_reg && out_lvl_reg == 8'd0))
        else $error("blanked item produced a nonzero drive result");

    // The level times the per-level step never exceeds the period width.
    a_sum_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.store == ST_SUM) |-> (prod_reg[39:32] == 8'd0))
        else $error("scaled level overflowed 32 bits");

endmodule

// ===== hdl/bltd_ctrl.sv =====
// Controller of the level-to-duty mapper: sequences capture, period,
// bound and span divisions, and result delivery.
// Depends on bltd_pkg for the command and status types.
`timescale 1ns / 1ps

module bltd_ctrl
    import bltd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PER    = 4'd1;
    localparam logic [3:0] S_PWAIT  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_DSTART = 4'd4;
    localparam logic [3:0] S_DWAIT  = 4'd5;
    localparam logic [3:0] S_LMUL   = 4'd6;
    localparam logic [3:0] S_LSUM   = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    // Which quantity the current multiply and divide pass produces.
    localparam logic [1:0] PH_LO   = 2'd0;
    localparam logic [1:0] PH_GAP  = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_SPAN = 2'd3;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PER;
                end
            end
            S_PER:
            begin
                if (sts.blank)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    phase_next = sts.lvl_ge_max ? PH_HI : PH_LO;
                    if (sts.mode_pwm)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DSEL_CLK;
                        state_next    = S_PWAIT;
                    end
                    else
                    begin
                        cmd.per_aux = 1'b1;
                        state_next  = S_MUL;
                    end
                end
            end
            S_PWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.store  = ST_PER;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = (phase_reg == PH_HI)  ? MS_HI :
                              (phase_reg == PH_GAP) ? MS_GAP : MS_LO;
                state_next  = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = (phase_reg == PH_SPAN) ? DSEL_SPAN : DSEL_PROD;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (sts.div_done)
                begin
                    case (phase_reg)
                        PH_LO:
                        begin
                            cmd.store = ST_LO;
                            if (sts.lvl_zero)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                phase_next = PH_GAP;
                                state_next = S_MUL;
                            end
                        end
                        PH_GAP:
                        begin
                            cmd.store  = ST_GAP;
                            phase_next = PH_SPAN;
                            state_next = S_DSTART;
                        end
                        PH_HI:
                        begin
                            cmd.store  = ST_CNT;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_LMUL;
                        end
                    endcase
                end
            end
            S_LMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_LVL;
                state_next  = S_LSUM;
            end
            S_LSUM:
            begin
                cmd.store  = ST_SUM;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_LO;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // A result is only loaded when the output register can take it.
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("result loaded over an untaken result");

    // The shared divider is never restarted mid-operation.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // A captured item always moves on to the period step.
    a_cap_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_PER))
        else $error("capture not followed by period step");

endmodule

// ===== hdl/backlight_level_to_duty.sv =====
// Top level of the backlight level-to-duty mapper: configuration registers
// and the stream ports around the controller and datapath.
// Depends on bltd_pkg, bltd_ctrl and bltd_dp.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  level in tdata, blank in tuser
//   m_axis    out        m_axis_tvalid / m_axis_tready  counts in tdata, command in tuser
//   cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One item is worked on at a time. Up to four divisions run per item on
// the shared 40-bit divider, which produces two quotient bits per cycle.
// Reset is asynchronous, active low; there is no clearing pass. A new item
// is accepted while a finished result waits in the output register.
`timescale 1ns / 1ps

module backlight_level_to_duty
    import bltd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input item.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] requested_level
    input  logic        s_axis_tuser,   // [0] blank
    // Result item.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [31:0] period_count, [63:32] duty_count,
                                        // [64] pwm_run, [72:65] applied_level, rest 0
    output logic [1:0]  m_axis_tuser,   // [1:0] command
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t        cfg_reg;
    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic [1:0]  out_command;
    logic [31:0] out_period;
    logic [31:0] out_duty;
    logic        out_run;
    logic [7:0]  out_level;

    // Configuration register bank; writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DRIVE_MODE:   cfg_reg.drive_mode      <= cfg_data[1:0];
                REG_MIN_DUTY_PCT: cfg_reg.min_duty_pct    <= cfg_data[6:0];
                REG_MAX_DUTY_PCT: cfg_reg.max_duty_pct    <= cfg_data[6:0];
                REG_MAX_LEVEL:    cfg_reg.max_level       <= cfg_data[7:0];
                REG_PWM_FREQ_HZ:  cfg_reg.pwm_freq_hz     <= cfg_data[15:0];
                REG_SRC_CLOCK_HZ: cfg_reg.source_clock_hz <= cfg_data;
                REG_VESA_BITS:    cfg_reg.vesa_bits       <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    bltd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bltd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .sts         (sts),
        .in_level    (s_axis_tdata),
        .in_blank    (s_axis_tuser),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_command (out_command),
        .out_period  (out_period),
        .out_duty    (out_duty),
        .out_run     (out_run),
        .out_level   (out_level)
    );

    // Result packing.
    assign m_axis_tdata = {7'd0, out_level, out_run, out_duty, out_period};
    assign m_axis_tuser = out_command;

endmodule

// ===== dv/backlight_level_to_duty_checker.sv =====
// Checker for the backlight level-to-duty mapper: watches the configuration,
// input and result channels, predicts each result and compares it field by field.
// Depends on bltd_pkg for the register layout, mode and command codes.
`timescale 1ns / 1ps

module backlight_level_to_duty_checker
    import bltd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] requested_level
    input  logic        s_axis_tuser,   // [0] blank
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,   // [31:0] period_count, [63:32] duty_count,
                                        // [64] pwm_run, [72:65] applied_level, rest 0
    input  logic [1:0]  m_axis_tuser,   // [1:0] command
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic [31:0] mismatches,
    output logic [31:0] awaited,
    output logic [31:0] results_checked,
    output logic [31:0] off_commands
);

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] period;
        logic [31:0] duty;
        logic        run;
        logic [7:0]  level;
    } duty_result_t;

    cfg_t         shadow = CFG_RESET;
    logic         backlight_lit = 1'b0;
    duty_result_t pending_duty[$];

    initial
    begin
        mismatches      = '0;
        awaited         = '0;
        results_checked = '0;
        off_commands    = '0;
    end

    // Map a clamped level onto a count between the two duty percentages of a period.
    function automatic logic [63:0] level_to_count(input logic [63:0] per,
                                                   input logic [7:0] lvl);
        logic [63:0] lo_pct;
        logic [63:0] hi_pct;
        logic [63:0] lo;
        logic [63:0] gap;
        logic [63:0] span;
        lo_pct = (shadow.min_duty_pct > PCT_FULL) ? 64'(PCT_FULL) : 64'(shadow.min_duty_pct);
        hi_pct = (shadow.max_duty_pct > PCT_FULL) ? 64'(PCT_FULL) : 64'(shadow.max_duty_pct);
        lo     = lo_pct * per / 64'(PCT_FULL);
        gap    = (64'(PCT_FULL) - hi_pct) * per / 64'(PCT_FULL);
        span   = (per >= lo + gap) ? per - lo - gap : 64'd0;
        if (lvl >= shadow.max_level)
            return hi_pct * per / 64'(PCT_FULL);
        if (lvl == 8'd0)
            return lo;
        // Here 1 <= lvl < max_level, so the divisor is nonzero.
        return 64'(lvl) * (span / 64'(shadow.max_level)) + lo;
    endfunction

    // Work out the result of one brightness update and advance the on/off state.
    function automatic duty_result_t predict_update(input logic [7:0] req, input logic blk);
        duty_result_t r;
        logic [7:0]   lvl;
        logic [63:0]  per;
        logic [63:0]  cnt;
        logic [31:0]  freq;
        r   = '0;
        per = '0;
        cnt = '0;
        if (blk)
        begin
            r.command     = backlight_lit ? CMD_OFF : CMD_NONE;
            backlight_lit = 1'b0;
        end
        else
        begin
            lvl       = (req > shadow.max_level) ? shadow.max_level : req;
            r.command = CMD_DRIVE;
            r.level   = lvl;
            case (shadow.drive_mode)
                MODE_HDR:
                begin
                    per = 64'(HDR_PERIOD);
                    cnt = level_to_count(per, lvl);
                    if (cnt == 64'd0)
                        cnt = 64'(HDR_FLOOR);
                    r.run = 1'b1;
                end
                MODE_VESA:
                begin
                    per   = (64'd1 << shadow.vesa_bits) - 64'd1;
                    cnt   = level_to_count(per, lvl);
                    r.run = 1'b1;
                end
                default:
                begin
                    // PWM counter; the unused mode code lands here as well.
                    freq = (shadow.pwm_freq_hz == 16'd0) ? 32'd1 : 32'(shadow.pwm_freq_hz);
                    per  = 64'(shadow.source_clock_hz / freq);
                    cnt  = level_to_count(per, lvl);
                    if (cnt == 64'd0)
                        r.run = 1'b0;
                    else
                    begin
                        if (cnt >= per)
                            cnt = 64'd0;
                        r.run = 1'b1;
                    end
                end
            endcase
            r.period      = per[31:0];
            r.duty        = cnt[31:0];
            backlight_lit = 1'b1;
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
                $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                         $realtime, results_checked, name, want, got);
        end
    endtask

    // Results are compared before a new item is queued in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin
        duty_result_t want;
        if (!rst_n)
        begin
            shadow        = CFG_RESET;
            backlight_lit = 1'b0;
            pending_duty.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DRIVE_MODE:   shadow.drive_mode      = cfg_data[1:0];
                    REG_MIN_DUTY_PCT: shadow.min_duty_pct    = cfg_data[6:0];
                    REG_MAX_DUTY_PCT: shadow.max_duty_pct    = cfg_data[6:0];
                    REG_MAX_LEVEL:    shadow.max_level       = cfg_data[7:0];
                    REG_PWM_FREQ_HZ:  shadow.pwm_freq_hz     = cfg_data[15:0];
                    REG_SRC_CLOCK_HZ: shadow.source_clock_hz = cfg_data;
                    REG_VESA_BITS:    shadow.vesa_bits       = cfg_data[4:0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_duty.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result item: tuser 0x%0h tdata 0x%0h",
                                 $realtime, m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = pending_duty.pop_front();
                    compare_field("command", 32'(want.command), 32'(m_axis_tuser));
                    compare_field("period_count", want.period, m_axis_tdata[31:0]);
                    compare_field("duty_count", want.duty, m_axis_tdata[63:32]);
                    compare_field("pwm_run", 32'(want.run), 32'(m_axis_tdata[64]));
                    compare_field("applied_level", 32'(want.level), 32'(m_axis_tdata[72:65]));
                    compare_field("tdata padding", 32'd0, 32'(m_axis_tdata[79:73]));
                    if (want.command == CMD_OFF)
                        off_commands = off_commands + 1;
                end
                results_checked = results_checked + 1;
            end

            if (s_axis_tvalid && s_axis_tready)
                pending_duty.push_back(predict_update(s_axis_tdata, s_axis_tuser));
        end
        awaited = pending_duty.size();
    end

endmodule

// ===== dv/backlight_level_to_duty_tb.sv =====
// Testbench top for the backlight level-to-duty mapper: clock, reset, register
// programming, brightness updates and result back-pressure around the block.
// Depends on bltd_pkg, backlight_level_to_duty and backlight_level_to_duty_checker.
`timescale 1ns / 1ps

module backlight_level_to_duty_tb;
    import bltd_pkg::*;

    localparam int ITEMS_PER_SETTING = 50;
    localparam int RANDOM_SETTINGS   = 26;
    localparam int HOLD_AT_RESULT    = 300;
    localparam int HOLD_CYCLES       = 400;
    localparam int SETTLE_CYCLES     = 8;
    localparam int END_CYCLES        = 120;
    localparam int WATCHDOG_NS       = 10_000_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [31:0] mismatches;
    logic [31:0] awaited;
    logic [31:0] results_checked;
    logic [31:0] off_commands;

    // Both sides skip their random waits while this is set.
    bit          steady_flow = 1'b0;
    int unsigned levels_sent = 0;
    int unsigned settings_used = 0;
    cfg_t        active_cfg = CFG_RESET;

    backlight_level_to_duty dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    backlight_level_to_duty_checker duty_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .awaited         (awaited),
        .results_checked (results_checked),
        .off_commands    (off_commands)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(WATCHDOG_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic cfg_t make_cfg(input logic [1:0] mode, input logic [6:0] lo_pct,
                                      input logic [6:0] hi_pct, input logic [7:0] top_lvl,
                                      input logic [15:0] freq, input logic [31:0] src,
                                      input logic [4:0] bits);
        cfg_t c;
        c.drive_mode      = mode;
        c.min_duty_pct    = lo_pct;
        c.max_duty_pct    = hi_pct;
        c.max_level       = top_lvl;
        c.pwm_freq_hz     = freq;
        c.source_clock_hz = src;
        c.vesa_bits       = bits;
        return c;
    endfunction

    // Mostly typical values, with each field at one of its extremes now and then.
    function automatic cfg_t random_setting();
        cfg_t c;
        c.drive_mode   = 2'($urandom_range(0, 3));
        c.min_duty_pct = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                     : 7'($urandom_range(0, 50));
        c.max_duty_pct = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                     : 7'($urandom_range(50, 100));
        case ($urandom_range(0, 7))
            0:       c.max_level = 8'd0;
            1:       c.max_level = 8'd255;
            default: c.max_level = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 7))
            0:       c.pwm_freq_hz = 16'd0;
            1:       c.pwm_freq_hz = 16'hFFFF;
            default: c.pwm_freq_hz = 16'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 7))
            0:       c.source_clock_hz = 32'd0;
            1:       c.source_clock_hz = 32'hFFFF_FFFF;
            2:       c.source_clock_hz = 32'($urandom_range(0, 200000));
            default: c.source_clock_hz = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       c.vesa_bits = 5'd0;
            1:       c.vesa_bits = 5'd31;
            default: c.vesa_bits = 5'($urandom_range(1, 16));
        endcase
        return c;
    endfunction

    // Caller lowers cfg_valid after the last write of a batch.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic program_regs(input cfg_t c);
        write_reg(REG_DRIVE_MODE,   32'(c.drive_mode));
        write_reg(REG_MIN_DUTY_PCT, 32'(c.min_duty_pct));
        write_reg(REG_MAX_DUTY_PCT, 32'(c.max_duty_pct));
        write_reg(REG_MAX_LEVEL,    32'(c.max_level));
        write_reg(REG_PWM_FREQ_HZ,  32'(c.pwm_freq_hz));
        write_reg(REG_SRC_CLOCK_HZ, c.source_clock_hz);
        write_reg(REG_VESA_BITS,    32'(c.vesa_bits));
        cfg_valid     <= 1'b0;
        active_cfg    = c;
        settings_used = settings_used + 1;
    endtask

    // Offer one brightness update after a random gap; returns at the next falling edge.
    task automatic send_level(input logic [7:0] lvl, input logic blk);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= lvl;
        s_axis_tuser  <= blk;
        do @(posedge clk); while (!s_axis_tready);
        levels_sent = levels_sent + 1;
        @(negedge clk);
    endtask

    // Stop offering and wait until every result of the batch has come back.
    task automatic settle(input int unsigned extra);
        s_axis_tvalid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off that backs up the input.
    initial
    begin : result_sink
        int unsigned pause;
        int unsigned taken;
        taken         = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            pause = steady_flow ? 0 : $urandom_range(0, 10);
            if (taken == HOLD_AT_RESULT)
                pause = HOLD_CYCLES;
            if (pause > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken = taken + 1;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        cfg_t        c;
        logic [7:0]  lvl;
        int unsigned pick;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: blank while off, level extremes, clamping, then off and off again.
        send_level(8'd0, 1'b1);
        send_level(8'd0, 1'b0);
        send_level(8'd1, 1'b0);
        send_level(8'd50, 1'b0);
        send_level(8'd99, 1'b0);
        send_level(8'd100, 1'b0);
        send_level(8'd255, 1'b0);
        send_level(8'hAA, 1'b0);
        send_level(8'h55, 1'b0);
        send_level(8'h7F, 1'b1);
        send_level(8'hFF, 1'b1);
        settle(SETTLE_CYCLES);

        // HDR with a zero floor percentage: level 0 maps to the minimum count of 3.
        program_regs(make_cfg(MODE_HDR, 7'd0, 7'd100, 8'd255, 16'd1000, 32'd1000, 5'd8));
        send_level(8'd0, 1'b0);
        send_level(8'd255, 1'b0);
        send_level(8'd128, 1'b0);
        settle(SETTLE_CYCLES);

        // VESA with zero bits gives a zero period.
        program_regs(make_cfg(MODE_VESA, 7'd10, 7'd90, 8'd100, 16'd1, 32'd1, 5'd0));
        send_level(8'd77, 1'b0);
        settle(SETTLE_CYCLES);

        // VESA with the widest bit count and percentages above 100.
        program_regs(make_cfg(MODE_VESA, 7'd127, 7'd127, 8'd200, 16'd1, 32'd1, 5'd31));
        send_level(8'd3, 1'b0);
        send_level(8'd255, 1'b0);
        settle(SETTLE_CYCLES);

        // Unused mode code with crossed percentages and a zero maximum level.
        program_regs(make_cfg(2'd3, 7'd100, 7'd0, 8'd0, 16'd1000, 32'd128000000, 5'd16));
        send_level(8'd0, 1'b0);
        send_level(8'd200, 1'b0);
        settle(SETTLE_CYCLES);

        // Source clock slower than the PWM frequency: zero period, output disabled.
        program_regs(make_cfg(MODE_PWM, 7'd10, 7'd90, 8'd100, 16'd1000, 32'd999, 5'd16));
        send_level(8'd50, 1'b0);
        settle(SETTLE_CYCLES);

        // Zero frequency counts as one; full scale reaches the period and runs full on.
        program_regs(make_cfg(MODE_PWM, 7'd0, 7'd100, 8'd100, 16'd0, 32'hFFFF_FFFF, 5'd16));
        send_level(8'd255, 1'b0);
        send_level(8'd0, 1'b0);
        send_level(8'd17, 1'b0);
        settle(SETTLE_CYCLES);

        // Random part: a fresh register setting per batch of updates.
        for (int s = 0; s < RANDOM_SETTINGS; s++)
        begin
            if (s == 0)
                c = make_cfg(2'd0, 7'd0, 7'd0, 8'd0, 16'd0, 32'd0, 5'd0);
            else if (s == 1)
                c = make_cfg(2'd3, 7'd127, 7'd127, 8'd255, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
            else
                c = random_setting();
            steady_flow = (s % 4 == 3);
            program_regs(c);
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       lvl = 8'd0;
                    1:       lvl = 8'd255;
                    2:       lvl = active_cfg.max_level;
                    3:       lvl = active_cfg.max_level - 8'd1;
                    default: lvl = 8'($urandom_range(0, 255));
                endcase
                send_level(lvl, $urandom_range(0, 3) == 0);
            end
            settle(SETTLE_CYCLES);
        end
        steady_flow = 1'b0;

        settle(END_CYCLES);
        $display("Drove %0d brightness updates under %0d register settings, all mode codes.",
                 levels_sent, settings_used + 1);
        $display("Checked %0d results field by field, %0d of them turn-off commands.",
                 results_checked, off_commands);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
